// ===== design/dlw_pkg.sv =====
package dlw_pkg;

    localparam int ADDR_BITS_DEF   = 21;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PTR_BITS   = 24;
    localparam int FETCH_BITS = 21;
    localparam int LIMIT_BITS = 21;
    localparam int COUNT_BITS = 22;
    localparam int TOTAL_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam int ADD_BITS   = 9;

    localparam logic [LIMIT_BITS-1:0] STEP_LIMIT_RESET = LIMIT_BITS'(2000000);
    localparam logic [PTR_BITS-1:0]   MARK_NONE        = 24'hffffff;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX        = '1;
    localparam int                    END_BIT          = 23;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef enum logic [1:0] {
        STOP_NONE  = 2'd0,
        STOP_END   = 2'd1,
        STOP_LOOP  = 2'd2,
        STOP_LIMIT = 2'd3
    } stop_t;

    // Classified request as it travels from front to back.
    typedef struct packed {
        logic                is_start;
        logic                end_mark;
        logic [ADD_BITS-1:0] add_words;
    } ctl_t;

endpackage

// ===== design/dma_linked_list_size_walker_top.sv =====
// Linked-list size walker: a start request (s_kind = 0) opens a walk at
// s_start_address and the block answers with a fetch request for the first
// header; each header request (s_kind = 1) carrying the fetched word adds its
// top byte plus one to the running total and either yields the next fetch
// request or ends the walk with m_done_res = 1, m_fetch_address = 0 and a
// stop reason (end marker in pointer bit 23, loop hit on one of the two
// remembered marks, or step limit passed). Every request that belongs to a
// walk yields exactly one result; a header request with no walk open yields
// none. The block takes one request per clock and retires one per clock while
// m_ready stays high: requests pass a classify register, a QUEUE_DEPTH entry
// queue and the walk state update, and the read-modify-write of the walk state
// in the back end sets the one-per-cycle rate. Write step_limit only while no
// walk result is pending; it resets to 2000000.
module dma_linked_list_size_walker_top #(
    parameter int ADDR_BITS   = dlw_pkg::ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = dlw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dlw_pkg::LIMIT_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [dlw_pkg::PTR_BITS-1:0]   s_start_address,
    input  logic [dlw_pkg::WORD_BITS-1:0]  s_header_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dlw_pkg::FETCH_BITS-1:0] m_fetch_address,
    output logic                           m_done_res,
    output logic [dlw_pkg::TOTAL_BITS-1:0] m_total_words,
    output logic [1:0]                     m_stop_reason
);
    import dlw_pkg::*;

    localparam int CTL_W   = $bits(ctl_t);
    localparam int QUEUE_W = CTL_W + ADDR_BITS;

    // Front end: classified request.
    logic                 f_valid;
    logic                 f_ready;
    ctl_t                 f_ctl;
    logic [ADDR_BITS-1:0] f_addr;

    // Queue output toward the back end.
    logic                 q_valid;
    logic                 q_ready;
    logic [QUEUE_W-1:0]   q_data;
    ctl_t                 q_ctl;
    logic [ADDR_BITS-1:0] q_addr;

    // Classify: mask the pointer, flag the end marker, precompute the add.
    dlw_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_start_address (s_start_address),
        .s_header_word   (s_header_word),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_ctl         (f_ctl),
        .out_addr        (f_addr)
    );

    // Decouple classification from the walk so either side can stall.
    dlw_queue #(
        .WIDTH (QUEUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_ctl, f_addr}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign q_ctl  = q_data[QUEUE_W-1:ADDR_BITS];
    assign q_addr = q_data[ADDR_BITS-1:0];

    // Walk state, loop marks, step limit and the output register.
    dlw_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (q_valid),
        .in_ready        (q_ready),
        .in_ctl          (q_ctl),
        .in_addr         (q_addr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fetch_address (m_fetch_address),
        .m_done_res      (m_done_res),
        .m_total_words   (m_total_words),
        .m_stop_reason   (m_stop_reason)
    );

    // A finished walk never carries a fetch address and always names a cause.
    a_done_shape : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |->
            (m_fetch_address == '0 && m_stop_reason != STOP_NONE))
        else $error("done result with fetch address or without stop reason");

    // A fetch request never carries a stop reason.
    a_fetch_shape : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_stop_reason == STOP_NONE))
        else $error("fetch request with stop reason");

    // No result leaves right after reset.
    a_reset_quiet : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ===== design/dlw_front.sv =====
module dlw_front #(
    parameter int ADDR_BITS = dlw_pkg::ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [dlw_pkg::PTR_BITS-1:0]  s_start_address,
    input  logic [dlw_pkg::WORD_BITS-1:0] s_header_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dlw_pkg::ctl_t                 out_ctl,
    output logic [ADDR_BITS-1:0]          out_addr
);
    import dlw_pkg::*;

    logic                 valid_reg;
    ctl_t                 ctl_reg;
    ctl_t                 ctl_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [PTR_BITS-1:0]  ptr;

    assign s_ready = !valid_reg || out_ready;

    // Pick the pointer, mask it to a word address, precompute the header add.
    always_comb begin
        ptr                = (s_kind == KIND_HEADER) ? s_header_word[PTR_BITS-1:0]
                                                     : s_start_address;
        addr_next          = {ptr[ADDR_BITS-1:2], 2'b00};
        ctl_next.is_start  = (s_kind == KIND_START);
        ctl_next.end_mark  = s_header_word[END_BIT];
        ctl_next.add_words = {1'b0, s_header_word[WORD_BITS-1:PTR_BITS]} + ADD_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ctl_reg  <= ctl_next;
            addr_reg <= addr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_addr  = addr_reg;

endmodule

// ===== design/dlw_queue.sv =====
module dlw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dlw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/dlw_back.sv =====
module dlw_back #(
    parameter int ADDR_BITS = dlw_pkg::ADDR_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [dlw_pkg::LIMIT_BITS-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dlw_pkg::ctl_t                  in_ctl,
    input  logic [ADDR_BITS-1:0]           in_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dlw_pkg::FETCH_BITS-1:0] m_fetch_address,
    output logic                           m_done_res,
    output logic [dlw_pkg::TOTAL_BITS-1:0] m_total_words,
    output logic [1:0]                     m_stop_reason
);
    import dlw_pkg::*;

    logic [LIMIT_BITS-1:0] step_limit_reg;
    logic [TOTAL_BITS-1:0] total_reg,   total_next,   total_base;
    logic [COUNT_BITS-1:0] count_reg,   count_next,   count_base;
    logic [PTR_BITS-1:0]   prev_reg,    prev_next,    prev_base;
    logic [PTR_BITS-1:0]   low_reg,     low_next,     low_base;
    logic [PTR_BITS-1:0]   high_reg,    high_next,    high_base;
    logic                  walking_reg, walking_next;

    logic                  out_valid_reg;
    logic [FETCH_BITS-1:0] fetch_reg,   fetch_next;
    logic                  done_reg,    done_next;
    logic [TOTAL_BITS-1:0] sum_reg;
    stop_t                 stop_reg,    stop_next;

    logic                  pop;
    logic                  emit;
    logic [PTR_BITS-1:0]   a24;

    assign in_ready = !out_valid_reg || m_ready;
    assign pop      = in_valid && in_ready;
    assign a24      = PTR_BITS'(in_addr);

    always_comb begin
        if (in_ctl.is_start) begin
            total_base = TOTAL_BITS'(1);
            count_base = '0;
            prev_base  = MARK_NONE;
            low_base   = MARK_NONE;
            high_base  = MARK_NONE;
        end else begin
            total_base = total_reg + TOTAL_BITS'(in_ctl.add_words);
            count_base = count_reg;
            prev_base  = prev_reg;
            low_base   = low_reg;
            high_base  = high_reg;
        end

        total_next   = total_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        walking_next = walking_reg;
        emit         = 1'b0;
        fetch_next   = '0;
        done_next    = 1'b0;
        stop_next    = STOP_NONE;

        // Drop a header that arrives with no walk in progress.
        if (in_ctl.is_start || walking_reg) begin
            total_next = total_base;
            count_next = count_base;
            prev_next  = prev_base;
            low_next   = low_base;
            high_next  = high_base;
            emit       = 1'b1;
            if (!in_ctl.is_start && in_ctl.end_mark) begin
                walking_next = 1'b0;
                done_next    = 1'b1;
                stop_next    = STOP_END;
            end else begin
                count_next = (count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
                if (count_base > COUNT_BITS'(step_limit_reg)) begin
                    walking_next = 1'b0;
                    done_next    = 1'b1;
                    stop_next    = STOP_LIMIT;
                end else if (a24 == low_base || a24 == high_base) begin
                    walking_next = 1'b0;
                    done_next    = 1'b1;
                    stop_next    = STOP_LOOP;
                end else begin
                    if (a24 < prev_base) begin
                        low_next = a24;
                    end else begin
                        high_next = a24;
                    end
                    prev_next    = a24;
                    walking_next = 1'b1;
                    fetch_next   = a24[FETCH_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_limit_reg <= STEP_LIMIT_RESET;
            walking_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_limit_reg <= cfg_wr_data;
            end
            if (pop) begin
                walking_reg   <= walking_next;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            total_reg <= total_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
        if (pop && emit) begin
            fetch_reg <= fetch_next;
            done_reg  <= done_next;
            sum_reg   <= total_next;
            stop_reg  <= stop_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_fetch_address = fetch_reg;
    assign m_done_res      = done_reg;
    assign m_total_words   = sum_reg;
    assign m_stop_reason   = stop_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dlw_pkg::*;

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam logic [PTR_BITS-1:0] WORD_ADDR_MASK = PTR_BITS'(((1 << ADDR_BITS) - 1) & ~3);
    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

    // Cycles to let the pipe settle before a register write or the final verdict:
    // classify stage, queue, walk-state update, plus margin.
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 190;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [FETCH_BITS-1:0] fetch;
        logic                  done;
        logic [TOTAL_BITS-1:0] total;
        stop_t                 reason;
    } walk_result_t;

    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_TYPED,
        CHECK_NONE
    } row_check_t;

    typedef struct packed {
        logic                 kind;
        logic [PTR_BITS-1:0]  addr;
        logic [WORD_BITS-1:0] word;
        row_check_t           check;
        walk_result_t         typed;
    } directed_row_t;

    localparam walk_result_t NO_RESULT = '0;
    localparam int DIRECTED_COUNT = 21;

    // Directed requests. Typed rows carry a result that follows straight from the
    // list contents; the rest go through the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // header with no walk open: dropped
        '{KIND_HEADER, 24'h000000, 32'hffff_ffff, CHECK_NONE, NO_RESULT},
        '{KIND_START, 24'h000000, 32'h0000_0000, CHECK_TYPED,
          '{21'h000000, 1'b0, 32'd1, STOP_NONE}},
        // pointer back to itself: loop on the first mark
        '{KIND_HEADER, 24'h000000, 32'h0000_0000, CHECK_TYPED,
          '{21'h000000, 1'b1, 32'd2, STOP_LOOP}},
        '{KIND_HEADER, 24'hffffff, 32'h1234_5678, CHECK_NONE, NO_RESULT},
        // top address masks down to the last word
        '{KIND_START, 24'hffffff, 32'hffff_ffff, CHECK_TYPED,
          '{21'h1ffffc, 1'b0, 32'd1, STOP_NONE}},
        // largest word count with the end marker
        '{KIND_HEADER, 24'h000000, 32'hff80_0000, CHECK_TYPED,
          '{21'h000000, 1'b1, 32'd257, STOP_END}},
        '{KIND_START, 24'h000003, 32'h0000_0000, CHECK_TYPED,
          '{21'h000000, 1'b0, 32'd1, STOP_NONE}},
        '{KIND_HEADER, 24'h000000, 32'h0000_0010, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'h7f00_0008, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'h0000_0020, CHECK_MODEL, NO_RESULT},
        // revisit the low mark
        '{KIND_HEADER, 24'h000000, 32'h0100_0008, CHECK_MODEL, NO_RESULT},
        '{KIND_START, 24'h0abcde, 32'hdead_beef, CHECK_MODEL, NO_RESULT},
        // pointer bits above the address width are dropped
        '{KIND_HEADER, 24'h000000, 32'h0060_0004, CHECK_MODEL, NO_RESULT},
        // start in the middle of a walk abandons it
        '{KIND_START, 24'h000100, 32'h0000_0000, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'h8000_0200, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'h0000_0100, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'hff7f_ffff, CHECK_NONE, NO_RESULT},
        '{KIND_START, 24'h7ffffe, 32'h0000_0000, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'h0080_0000, CHECK_TYPED,
          '{21'h000000, 1'b1, 32'd2, STOP_END}},
        // bit 23 of a start address is not an end marker
        '{KIND_START, 24'h800040, 32'h0000_0000, CHECK_MODEL, NO_RESULT},
        '{KIND_HEADER, 24'h000000, 32'hffa5_a5a4, CHECK_MODEL, NO_RESULT}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [LIMIT_BITS-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [PTR_BITS-1:0]   s_start_address;
    logic [WORD_BITS-1:0]  s_header_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [FETCH_BITS-1:0] m_fetch_address;
    logic                  m_done_res;
    logic [TOTAL_BITS-1:0] m_total_words;
    logic [1:0]            m_stop_reason;

    // Predictor state: a private copy of the walk registers.
    logic [LIMIT_BITS-1:0] wk_limit;
    logic [TOTAL_BITS-1:0] wk_total;
    logic [COUNT_BITS-1:0] wk_steps;
    logic [PTR_BITS-1:0]   wk_prev;
    logic [PTR_BITS-1:0]   wk_low;
    logic [PTR_BITS-1:0]   wk_high;
    logic                  wk_walking;

    walk_result_t walk_results_due [$];
    int unsigned  error_count = 0;
    bit           hold_wanted = 1'b0;

    always #6 aclk = ~aclk;

    dma_linked_list_size_walker_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_start_address (s_start_address),
        .s_header_word   (s_header_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fetch_address (m_fetch_address),
        .m_done_res      (m_done_res),
        .m_total_words   (m_total_words),
        .m_stop_reason   (m_stop_reason)
    );

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 60);
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function automatic void walk_clear();
        wk_total   = '0;
        wk_steps   = '0;
        wk_prev    = MARK_NONE;
        wk_low     = MARK_NONE;
        wk_high    = MARK_NONE;
        wk_walking = 1'b0;
    endfunction

    // One list step: mask to a word address, test the step limit against the steps so far
    // and count this one, then check the two loop marks before moving the marks and asking for the header.
    function automatic walk_result_t walk_step(input logic [PTR_BITS-1:0] ptr);
        logic [PTR_BITS-1:0] word_addr;
        logic                over;
        walk_result_t        res;
        word_addr = ptr & WORD_ADDR_MASK;
        over = wk_steps > COUNT_BITS'(wk_limit);
        if (wk_steps != COUNT_MAX) wk_steps++;
        res = '{FETCH_BITS'(0), 1'b1, wk_total, STOP_NONE};
        if (over) begin
            res.reason = STOP_LIMIT;
            wk_walking = 1'b0;
        end else if (word_addr == wk_low || word_addr == wk_high) begin
            res.reason = STOP_LOOP;
            wk_walking = 1'b0;
        end else begin
            if (word_addr < wk_prev) wk_low = word_addr;
            else wk_high = word_addr;
            wk_prev   = word_addr;
            res.fetch = word_addr[FETCH_BITS-1:0];
            res.done  = 1'b0;
        end
        return res;
    endfunction

    // Advance the walk by one accepted request; returns 0 when it yields no result.
    function automatic bit walk_predict(input logic kind, input logic [PTR_BITS-1:0] start_addr,
                                        input logic [WORD_BITS-1:0] word,
                                        output walk_result_t res);
        res = '0;
        if (kind == KIND_START) begin
            walk_clear();
            wk_total   = 32'd1;
            wk_walking = 1'b1;
            res = walk_step(start_addr);
            return 1'b1;
        end
        if (!wk_walking) return 1'b0;
        wk_total = wk_total + TOTAL_BITS'(word[31:24]) + 32'd1;
        if (word[END_BIT]) begin
            wk_walking = 1'b0;
            res = '{FETCH_BITS'(0), 1'b1, wk_total, STOP_END};
            return 1'b1;
        end
        res = walk_step(word[PTR_BITS-1:0]);
        return 1'b1;
    endfunction

    // Offer one request, hold it until taken, then record what it must produce.
    task automatic offer_request(input logic kind, input logic [PTR_BITS-1:0] addr,
                                 input logic [WORD_BITS-1:0] word, input row_check_t check,
                                 input walk_result_t typed);
        walk_result_t res;
        bit           has_result;
        int unsigned  gap;
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_start_address <= addr;
        s_header_word   <= word;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        has_result = walk_predict(kind, addr, word, res);
        case (check)
            CHECK_MODEL: begin
                if (has_result) walk_results_due.push_back(res);
            end
            CHECK_TYPED: begin
                walk_results_due.push_back(typed);
            end
            default: begin
            end
        endcase
        // Drop valid only when a gap follows; otherwise keep it high for the next one.
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Write the step limit only once the pipe has fully drained.
    task automatic set_step_limit(input logic [LIMIT_BITS-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (walk_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wk_limit = value;
    endtask

    // Result side: check every accepted result against the oldest expectation.
    always @(posedge aclk) begin : result_check
        walk_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (walk_results_due.size() == 0) begin
                flag_error($sformatf("unexpected result fetch=%h done=%b total=%0d reason=%0d",
                                     m_fetch_address, m_done_res, m_total_words,
                                     m_stop_reason));
            end else begin
                want = walk_results_due.pop_front();
                if (m_fetch_address !== want.fetch || m_done_res !== want.done ||
                        m_total_words !== want.total || m_stop_reason !== want.reason) begin
                    flag_error($sformatf(
                        "fetch %h/%h done %b/%b total %0d/%0d reason %0d/%0d (exp/act)",
                        want.fetch, m_fetch_address, want.done, m_done_res,
                        want.total, m_total_words, want.reason, m_stop_reason));
                end
            end
        end
    end

    // Result side back-pressure: random stalls, calm stretches, and one long hold
    // that the stimulus asks for so the queue fills and s_ready drops.
    initial begin : result_sink
        int unsigned calm_left;
        bit          hold_done;
        calm_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_wanted && !hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (calm_left > 0 || $urandom_range(0, 99) < 65) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);
        end
    end

    initial begin : stimulus
        logic [LIMIT_BITS-1:0] limit;
        logic [PTR_BITS-1:0]   ptr;
        logic [PTR_BITS-1:0]   addr;
        logic [WORD_BITS-1:0]  word;
        logic                  kind;
        int unsigned           counted;
        int unsigned           r;
        int unsigned           waited;

        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        s_valid         <= 1'b0;
        s_kind          <= KIND_START;
        s_start_address <= '0;
        s_header_word   <= '0;
        walk_clear();
        wk_limit = STEP_LIMIT_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset step limit.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            offer_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].word,
                          DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].typed);
        end

        // Random walks, one step-limit setting per phase, extremes included.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: limit = '0;
                1: limit = 21'd1;
                2: limit = LIMIT_MAX;
                3: limit = 21'd3;
                4: limit = LIMIT_BITS'($urandom_range(4, 40));
                5: limit = STEP_LIMIT_RESET;
                6: limit = 21'd2;
                default: limit = LIMIT_BITS'($urandom_range(0, 12));
            endcase
            set_step_limit(limit);
            counted = 0;
            while (counted < PHASE_REQUESTS) begin
                r = $urandom_range(0, 99);
                word = $urandom();
                addr = PTR_BITS'($urandom());
                if (!wk_walking) begin
                    // Mostly open a new walk; sometimes send a stray header.
                    kind = (r < 85) ? KIND_START : KIND_HEADER;
                    if (kind == KIND_START && $urandom_range(0, 9) < 3)
                        addr = PTR_BITS'($urandom_range(0, 'hff));
                end else if (r < 4) begin
                    kind = KIND_START;
                end else begin
                    kind = KIND_HEADER;
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        ptr = {1'b1, 23'($urandom())};
                    end else if (r < 16) begin
                        // Same word again, with alias bits above the width and below the word.
                        ptr = wk_prev | (PTR_BITS'($urandom_range(0, 3)) << ADDR_BITS)
                              | PTR_BITS'($urandom_range(0, 3));
                    end else if (r < 22) begin
                        ptr = ($urandom_range(0, 1) == 1 && wk_low != MARK_NONE) ? wk_low
                              : (wk_high != MARK_NONE ? wk_high : wk_low);
                    end else if (r < 61) begin
                        ptr = PTR_BITS'($urandom_range(0, 'h3ff));
                    end else begin
                        ptr = {1'b0, 23'($urandom())};
                    end
                    word = {8'($urandom()), ptr};
                end
                if (kind == KIND_START || wk_walking) counted++;
                // Stall the result side mid-phase while requests keep coming.
                if (phase == 2 && counted == 100) hold_wanted = 1'b1;
                offer_request(kind, addr, word, CHECK_MODEL, NO_RESULT);
            end
        end

        // Drain, then let the pipe settle before the verdict.
        s_valid <= 1'b0;
        waited = 0;
        while (walk_results_due.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (walk_results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", walk_results_due.size()));
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
